/* rtl/quaternion_alu_defines.svh */
// Assertion macros used by the quaternion ALU checker.
`ifndef QUATERNION_ALU_DEFINES_SVH
`define QUATERNION_ALU_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define QALU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define QALU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/qalu_pkg.sv */
// Types, codes and helpers shared by the quaternion ALU modules.
package qalu_pkg;

    // Opcodes
    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_SUB   = 3'd1;
    localparam logic [2:0] OP_SCALE = 3'd2;
    localparam logic [2:0] OP_MUL   = 3'd3;
    localparam logic [2:0] OP_CONJ  = 3'd4;
    localparam logic [2:0] OP_NORM  = 3'd5;
    localparam logic [2:0] OP_INV   = 3'd6;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;

    // Q16.16 range ends
    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] a_s;
        logic signed [31:0] a_i;
        logic signed [31:0] a_j;
        logic signed [31:0] a_k;
        logic signed [31:0] b_s;
        logic signed [31:0] b_i;
        logic signed [31:0] b_j;
        logic signed [31:0] b_k;
        logic signed [31:0] scale_factor;
    } in_t;

    typedef struct packed {
        logic signed [31:0] r_s;
        logic signed [31:0] r_i;
        logic signed [31:0] r_j;
        logic signed [31:0] r_k;
        logic [1:0]         status;
    } out_t;

    // Classified command: opcode plus multiplier operands (B already chosen)
    typedef struct packed {
        logic [2:0]       kind;
        logic [3:0][31:0] a;
        logic [3:0][31:0] b;
    } cmd_t;

    // Saturate to Q16.16; bit 32 flags overflow
    function automatic logic [32:0] sat52(input logic signed [51:0] v);
        logic [32:0] r;
        if (v > 52'sd2147483647) begin
            r = {1'b1, Q_MAX};
        end else if (v < -52'sd2147483648) begin
            r = {1'b1, Q_MIN};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

endpackage

/* rtl/qalu_front.sv */
// Front end: input handshake and operand classification per opcode.
module qalu_front (
    input  logic              s_valid,
    output logic              s_ready,
    input  qalu_pkg::in_t     s_data,
    input  logic              q_full,
    output logic              q_push,
    output qalu_pkg::cmd_t    q_cmd
);

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;

    // Pick operand B for the product array: factor for scale, A itself for squares
    always_comb begin
        q_cmd.kind = s_data.opcode;
        q_cmd.a    = {s_data.a_k, s_data.a_j, s_data.a_i, s_data.a_s};
        unique case (s_data.opcode) inside
            qalu_pkg::OP_SCALE: begin
                q_cmd.b = {4{s_data.scale_factor}};
            end
            qalu_pkg::OP_NORM, qalu_pkg::OP_INV: begin
                q_cmd.b = {s_data.a_k, s_data.a_j, s_data.a_i, s_data.a_s};
            end
            default: begin
                q_cmd.b = {s_data.b_k, s_data.b_j, s_data.b_i, s_data.b_s};
            end
        endcase
    end

endmodule

/* rtl/qalu_fifo.sv */
// Command queue between front and back end.
module qalu_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  qalu_pkg::cmd_t push_cmd,
    output logic           full,
    output logic           pop_valid,
    input  logic           pop_ready,
    output qalu_pkg::cmd_t pop_cmd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    qalu_pkg::cmd_t    mem_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]     count_reg;
    logic              pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop       = pop_valid && pop_ready;
    assign pop_cmd   = mem_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/qalu_exec.sv */
// Back end: product array, accumulate, iterative root/divide, output register.
module qalu_exec (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  qalu_pkg::cmd_t cmd,
    output logic           m_valid,
    input  logic           m_ready,
    output qalu_pkg::out_t m_data
);

    // ---------------- stage 1: products ----------------
    logic                v1_reg;
    logic [2:0]          kind1_reg;
    logic [3:0][31:0]    a1_reg, b1_reg;
    logic signed [63:0]  p1_reg [4][4];

    // ---------------- stage 2: sums ----------------
    logic                v2_reg;
    logic [2:0]          kind2_reg;
    logic [3:0][31:0]    a2_reg;
    logic signed [51:0]  sum2_reg [4];
    logic [64:0]         s2_reg;

    // ---------------- iterator ----------------
    logic                it_run_reg;
    logic [5:0]          cnt_reg;
    logic [65:0]         rem_reg [4];
    logic [31:0]         quo_reg [4];
    logic [34:0]         rs_reg;
    logic [31:0]         root_reg;
    logic [63:0]         x_reg;

    logic                m_valid_reg;
    qalu_pkg::out_t      m_data_reg;

    logic signed [63:0]  rnd_full [4][4];
    logic signed [51:0]  r52 [4][4];
    logic signed [51:0]  sum_next [4];
    logic [64:0]         s_next;
    logic                norm_big, inv_zero, is_iter, it_done, out_free;
    logic                take2, adv2, adv1;
    logic [31:0]         amag [4];
    logic                cneg [4];
    qalu_pkg::out_t      out_next;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Pipeline control
    assign norm_big  = (s2_reg[64:62] != 3'd0);
    assign inv_zero  = (s2_reg == '0);
    assign is_iter   = (kind2_reg == qalu_pkg::OP_NORM && !norm_big) ||
                       (kind2_reg == qalu_pkg::OP_INV && !inv_zero);
    assign it_done   = cnt_reg[5];
    assign out_free  = !m_valid_reg || m_ready;
    assign take2     = v2_reg && out_free && (!is_iter || (it_run_reg && it_done));
    assign adv2      = !v2_reg || take2;
    assign adv1      = !v1_reg || adv2;
    assign cmd_ready = adv1;

    // Stage 1 registers: 16 parallel 32x32 products
    always_ff @(posedge aclk) begin
        if (adv1) begin
            kind1_reg <= cmd.kind;
            a1_reg    <= cmd.a;
            b1_reg    <= cmd.b;
            for (int x = 0; x < 4; x++) begin
                for (int y = 0; y < 4; y++) begin
                    p1_reg[x][y] <= $signed(cmd.a[x]) * $signed(cmd.b[y]);
                end
            end
        end
    end

    // Rounding of products and per-component sums
    always_comb begin
        for (int x = 0; x < 4; x++) begin
            for (int y = 0; y < 4; y++) begin
                rnd_full[x][y] = p1_reg[x][y] + 64'sd32768;
                r52[x][y]      = 52'($signed(rnd_full[x][y][63:16]));
            end
        end
        for (int n = 0; n < 4; n++) begin
            case (kind1_reg)
                qalu_pkg::OP_ADD:
                    sum_next[n] = 52'($signed(a1_reg[n])) + 52'($signed(b1_reg[n]));
                qalu_pkg::OP_SUB:
                    sum_next[n] = 52'($signed(a1_reg[n])) - 52'($signed(b1_reg[n]));
                qalu_pkg::OP_SCALE:
                    sum_next[n] = r52[n][n];
                qalu_pkg::OP_CONJ:
                    sum_next[n] = (n == 0) ? 52'($signed(a1_reg[n]))
                                           : -52'($signed(a1_reg[n]));
                default:
                    sum_next[n] = '0;
            endcase
        end
        // Hamilton product
        if (kind1_reg == qalu_pkg::OP_MUL) begin
            sum_next[0] = r52[0][0] - r52[1][1] - r52[2][2] - r52[3][3];
            sum_next[1] = r52[0][1] + r52[1][0] + r52[2][3] - r52[3][2];
            sum_next[2] = r52[0][2] - r52[1][3] + r52[2][0] + r52[3][1];
            sum_next[3] = r52[0][3] + r52[1][2] - r52[2][1] + r52[3][0];
        end
        // Exact sum of squares
        s_next = {1'b0, p1_reg[0][0]} + {1'b0, p1_reg[1][1]}
               + {1'b0, p1_reg[2][2]} + {1'b0, p1_reg[3][3]};
    end

    // Stage 2 registers
    always_ff @(posedge aclk) begin
        if (adv2) begin
            kind2_reg <= kind1_reg;
            a2_reg    <= a1_reg;
            s2_reg    <= s_next;
            for (int n = 0; n < 4; n++) begin
                sum2_reg[n] <= sum_next[n];
            end
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (adv1) begin
                v1_reg <= cmd_valid;
            end
            if (adv2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    // Iterator control: 32 steps for root or divide
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            it_run_reg <= 1'b0;
            cnt_reg    <= '0;
        end else if (take2) begin
            it_run_reg <= 1'b0;
        end else if (v2_reg && is_iter && !it_run_reg) begin
            it_run_reg <= 1'b1;
            cnt_reg    <= '0;
        end else if (it_run_reg && !it_done) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // Magnitude and sign of each conjugate component
    always_comb begin
        for (int n = 0; n < 4; n++) begin
            amag[n] = a2_reg[n][31] ? (~a2_reg[n] + 32'd1) : a2_reg[n];
            cneg[n] = (n == 0) ? a2_reg[n][31]
                               : (!a2_reg[n][31] && a2_reg[n] != 32'd0);
        end
    end

    // Iterator datapath: 4 restoring divider lanes, one root lane
    always_ff @(posedge aclk) begin
        logic [65:0] rem2;
        logic [34:0] rs_t, trial;
        if (v2_reg && is_iter && !it_run_reg) begin
            for (int n = 0; n < 4; n++) begin
                rem_reg[n] <= {34'd0, amag[n]};
                quo_reg[n] <= '0;
            end
            rs_reg   <= '0;
            root_reg <= '0;
            x_reg    <= s2_reg[63:0];
        end else if (it_run_reg && !it_done) begin
            for (int n = 0; n < 4; n++) begin
                rem2 = {rem_reg[n][64:0], 1'b0};
                if (rem2 >= {1'b0, s2_reg}) begin
                    rem_reg[n] <= rem2 - {1'b0, s2_reg};
                    quo_reg[n] <= {quo_reg[n][30:0], 1'b1};
                end else begin
                    rem_reg[n] <= rem2;
                    quo_reg[n] <= {quo_reg[n][30:0], 1'b0};
                end
            end
            rs_t  = {rs_reg[32:0], x_reg[63:62]};
            trial = {1'b0, root_reg, 2'b01};
            if (rs_t >= trial) begin
                rs_reg   <= rs_t - trial;
                root_reg <= {root_reg[30:0], 1'b1};
            end else begin
                rs_reg   <= rs_t;
                root_reg <= {root_reg[30:0], 1'b0};
            end
            x_reg <= {x_reg[61:0], 2'b00};
        end
    end

    // Result selection and saturation
    always_comb begin
        logic [32:0]      sv;
        logic [3:0][31:0] r;
        logic             ovf;
        r   = '0;
        ovf = 1'b0;
        sv  = '0;
        out_next.status = qalu_pkg::ST_OK;
        unique case (kind2_reg) inside
            qalu_pkg::OP_ADD, qalu_pkg::OP_SUB, qalu_pkg::OP_SCALE,
            qalu_pkg::OP_MUL, qalu_pkg::OP_CONJ: begin
                for (int n = 0; n < 4; n++) begin
                    sv   = qalu_pkg::sat52(sum2_reg[n]);
                    r[n] = sv[31:0];
                    ovf  = ovf | sv[32];
                end
            end
            qalu_pkg::OP_NORM: begin
                if (norm_big) begin
                    r[0] = qalu_pkg::Q_MAX;
                    ovf  = 1'b1;
                end else begin
                    r[0] = root_reg;
                end
            end
            qalu_pkg::OP_INV: begin
                if (!inv_zero) begin
                    for (int n = 0; n < 4; n++) begin
                        if ({33'd0, amag[n]} >= s2_reg) begin
                            r[n] = cneg[n] ? qalu_pkg::Q_MIN : qalu_pkg::Q_MAX;
                            ovf  = 1'b1;
                        end else if (cneg[n]) begin
                            if (quo_reg[n] > 32'h8000_0000) begin
                                r[n] = qalu_pkg::Q_MIN;
                                ovf  = 1'b1;
                            end else begin
                                r[n] = ~quo_reg[n] + 32'd1;
                            end
                        end else if (quo_reg[n][31]) begin
                            r[n] = qalu_pkg::Q_MAX;
                            ovf  = 1'b1;
                        end else begin
                            r[n] = quo_reg[n];
                        end
                    end
                end
            end
            default: begin
                r = '0;
            end
        endcase
        if (kind2_reg == qalu_pkg::OP_INV && inv_zero) begin
            out_next.status = qalu_pkg::ST_DIVZ;
        end else if (ovf) begin
            out_next.status = qalu_pkg::ST_OVF;
        end
        out_next.r_s = r[0];
        out_next.r_i = r[1];
        out_next.r_j = r[2];
        out_next.r_k = r[3];
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (take2) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take2) begin
            m_data_reg <= out_next;
        end
    end

endmodule

/* rtl/quaternion_alu.sv */
// Quaternion ALU top level: front end, command queue, back end.
//
//   channel | dir | ports                      | payload
//   --------+-----+----------------------------+----------------
//   s_      | in  | s_valid, s_ready, s_data   | qalu_pkg::in_t
//   m_      | out | m_valid, m_ready, m_data   | qalu_pkg::out_t
//
// Add, sub, scale, multiply and conjugate: the input transfer passes the queue,
// products, sums and output register, one transfer per cycle unless m_ready or an iterating item holds them.
// Norm and inverse go through the shared 32-step root/divide iterator in the
// back end, which holds later items behind it.
// The queue keeps taking transfers while the back end is busy, up to QUEUE_DEPTH.
// aresetn is synchronous, active low; it empties the queue and all stages.
// m_data holds steady while m_valid is high and m_ready low.
module quaternion_alu #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  qalu_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output qalu_pkg::out_t m_data
);

    logic           q_full, q_push, q_valid, q_ready;
    qalu_pkg::cmd_t q_cmd, e_cmd;

    qalu_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (q_cmd)
    );

    qalu_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (q_cmd),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop_ready (q_ready),
        .pop_cmd   (e_cmd)
    );

    qalu_exec u_exec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (e_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

/* rtl/qalu_checker.sv */
// Port-level checks for the quaternion ALU, bound to the top level.
`include "quaternion_alu_defines.svh"

module qalu_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input qalu_pkg::in_t  s_data,
    input logic           m_valid,
    input logic           m_ready,
    input qalu_pkg::out_t m_data
);

    // A waiting input transfer stays offered with the same payload
    `QALU_ASSERT_NXT(a_in_hold, s_valid && !s_ready, s_valid && $stable(s_data), "input changed while waiting")

    // A stalled result stays offered
    `QALU_ASSERT_NXT(a_hold_valid, m_valid && !m_ready, m_valid, "result dropped while stalled")

    // A stalled result keeps its value
    `QALU_ASSERT_NXT(a_hold_data, m_valid && !m_ready, $stable(m_data), "result changed while stalled")

    // Only defined status codes leave the block
    `QALU_ASSERT_IMP(a_status_legal, m_valid, m_data.status == qalu_pkg::ST_OK || m_data.status == qalu_pkg::ST_OVF || m_data.status == qalu_pkg::ST_DIVZ, "undefined status code")

    // Inverse of zero returns all zero parts
    `QALU_ASSERT_IMP(a_divz_zero, m_valid && m_data.status == qalu_pkg::ST_DIVZ, m_data.r_s == 32'sd0 && m_data.r_i == 32'sd0 && m_data.r_j == 32'sd0 && m_data.r_k == 32'sd0, "nonzero result on inverse of zero")

endmodule

bind quaternion_alu qalu_checker u_qalu_checker (.*);

/* test/quaternion_alu_test.sv */
// Self-checking testbench for the quaternion ALU: directed corner cases plus random traffic.
`timescale 1ns / 1ps

module quaternion_alu_test;

    localparam longint LIM_HI = 64'sd2147483647;
    localparam longint LIM_LO = -64'sd2147483648;
    localparam int     CYCLE_LIMIT = 400000;

    logic           aclk;
    logic           aresetn;
    logic           s_valid;
    logic           s_ready;
    qalu_pkg::in_t  s_data;
    logic           m_valid;
    logic           m_ready = 1'b0;
    qalu_pkg::out_t m_data;

    qalu_pkg::out_t pending_results[$];
    int     mismatches;
    int     results_seen;
    int     items_sent;
    longint cycles = 0;
    bit     stall_enable;

    quaternion_alu uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // Clock and cycle watchdog
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    // Saturation with overflow flag
    function automatic longint clamp_q(input longint v, inout bit ovf);
        if (v > LIM_HI) begin
            ovf = 1'b1;
            return LIM_HI;
        end
        if (v < LIM_LO) begin
            ovf = 1'b1;
            return LIM_LO;
        end
        return v;
    endfunction

    // Q16.16 product rounded to nearest, ties upward (arithmetic shift floors)
    function automatic longint fix_mul(input longint x, input longint y);
        longint p;
        p = x * y + 64'sd32768;
        return p >>> 16;
    endfunction

    // Integer square root, bit by bit
    function automatic longint root_floor(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return longint'(res);
    endfunction

    // Expected result of one operation
    function automatic qalu_pkg::out_t quat_result(input qalu_pkg::in_t d);
        longint         a[4];
        longint         b[4];
        longint         r[4];
        longint         f;
        longint         cj;
        bit             ovf;
        logic [1:0]     st;
        logic [64:0]    sumsq;
        logic [63:0]    m;
        logic [95:0]    num;
        logic [95:0]    q;
        qalu_pkg::out_t o;
        a = '{longint'(d.a_s), longint'(d.a_i), longint'(d.a_j), longint'(d.a_k)};
        b = '{longint'(d.b_s), longint'(d.b_i), longint'(d.b_j), longint'(d.b_k)};
        f = longint'(d.scale_factor);
        r = '{0, 0, 0, 0};
        ovf = 1'b0;
        st = qalu_pkg::ST_OK;
        case (d.opcode) inside
            qalu_pkg::OP_ADD: begin
                for (int n = 0; n < 4; n++) r[n] = clamp_q(a[n] + b[n], ovf);
            end
            qalu_pkg::OP_SUB: begin
                for (int n = 0; n < 4; n++) r[n] = clamp_q(a[n] - b[n], ovf);
            end
            qalu_pkg::OP_SCALE: begin
                for (int n = 0; n < 4; n++) r[n] = clamp_q(fix_mul(a[n], f), ovf);
            end
            qalu_pkg::OP_MUL: begin
                r[0] = clamp_q(fix_mul(a[0], b[0]) - fix_mul(a[1], b[1])
                    - fix_mul(a[2], b[2]) - fix_mul(a[3], b[3]), ovf);
                r[1] = clamp_q(fix_mul(a[0], b[1]) + fix_mul(a[1], b[0])
                    + fix_mul(a[2], b[3]) - fix_mul(a[3], b[2]), ovf);
                r[2] = clamp_q(fix_mul(a[0], b[2]) - fix_mul(a[1], b[3])
                    + fix_mul(a[2], b[0]) + fix_mul(a[3], b[1]), ovf);
                r[3] = clamp_q(fix_mul(a[0], b[3]) + fix_mul(a[1], b[2])
                    - fix_mul(a[2], b[1]) + fix_mul(a[3], b[0]), ovf);
            end
            qalu_pkg::OP_CONJ: begin
                r[0] = a[0];
                for (int n = 1; n < 4; n++) r[n] = clamp_q(-a[n], ovf);
            end
            qalu_pkg::OP_NORM, qalu_pkg::OP_INV: begin
                sumsq = 0;
                for (int n = 0; n < 4; n++) begin
                    m = (a[n] < 0) ? 64'(-a[n]) : 64'(a[n]);
                    sumsq = sumsq + 65'(m * m);
                end
                if (d.opcode == qalu_pkg::OP_NORM) begin
                    if (sumsq >= (65'd1 << 62)) begin
                        r[0] = LIM_HI;
                        ovf = 1'b1;
                    end else begin
                        r[0] = root_floor(sumsq[63:0]);
                    end
                end else if (sumsq == 0) begin
                    st = qalu_pkg::ST_DIVZ;
                end else if (sumsq[64] == 1'b0) begin
                    for (int n = 0; n < 4; n++) begin
                        cj  = (n == 0) ? a[0] : -a[n];
                        num = 96'((cj < 0) ? -cj : cj) << 32;
                        q   = num / 96'(sumsq[63:0]);
                        if (cj < 0) begin
                            if (q > 96'd2147483648) begin
                                r[n] = LIM_LO;
                                ovf = 1'b1;
                            end else begin
                                r[n] = -longint'(q);
                            end
                        end else if (q > 96'd2147483647) begin
                            r[n] = LIM_HI;
                            ovf = 1'b1;
                        end else begin
                            r[n] = longint'(q);
                        end
                    end
                end
            end
            default: ;
        endcase
        if (st == qalu_pkg::ST_OK && ovf) st = qalu_pkg::ST_OVF;
        o.r_s = r[0][31:0];
        o.r_i = r[1][31:0];
        o.r_j = r[2][31:0];
        o.r_k = r[3][31:0];
        o.status = st;
        return o;
    endfunction

    // Send one item; burst gaps come from the caller
    task automatic send_item(input qalu_pkg::in_t d);
        s_valid <= 1'b1;
        s_data  <= d;
        pending_results.push_back(quat_result(d));
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic idle_cycles(input int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // Result checker and receiver stall pattern
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            qalu_pkg::out_t exp_r;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result %h", m_data);
            end else begin
                exp_r = pending_results.pop_front();
                results_seen++;
                if (exp_r.r_s !== m_data.r_s || exp_r.r_i !== m_data.r_i ||
                    exp_r.r_j !== m_data.r_j || exp_r.r_k !== m_data.r_k ||
                    exp_r.status !== m_data.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Result %0d: expected %h %h %h %h st %0d, got %h %h %h %h st %0d",
                            results_seen, exp_r.r_s, exp_r.r_i, exp_r.r_j, exp_r.r_k,
                            exp_r.status, m_data.r_s, m_data.r_i, m_data.r_j, m_data.r_k,
                            m_data.status);
                end
            end
        end
        m_ready <= stall_enable ? (($urandom_range(0, 9) < 7) ||
            ((cycles % 64) < 16)) : 1'b1;
    end

    function automatic logic [31:0] rand_part();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000);
            3: return 32'($signed($urandom_range(0, 32'h7F_FFFF)) - 32'sh40_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic qalu_pkg::in_t rand_item(input logic [2:0] op);
        qalu_pkg::in_t d;
        d.opcode = op;
        d.a_s = rand_part(); d.a_i = rand_part(); d.a_j = rand_part(); d.a_k = rand_part();
        d.b_s = rand_part(); d.b_i = rand_part(); d.b_j = rand_part(); d.b_k = rand_part();
        d.scale_factor = rand_part();
        return d;
    endfunction

    function automatic qalu_pkg::in_t make_item(input logic [2:0] op, input logic [31:0] av,
                                                input logic [31:0] bv, input logic [31:0] fv);
        qalu_pkg::in_t d;
        d.opcode = op;
        d.a_s = av; d.a_i = av; d.a_j = av; d.a_k = av;
        d.b_s = bv; d.b_i = bv; d.b_j = bv; d.b_k = bv;
        d.scale_factor = fv;
        return d;
    endfunction

    // Extremes, every opcode, zero inverse, huge inverse, undefined opcode
    task automatic test_directed();
        logic [2:0] ops[7] = '{qalu_pkg::OP_ADD, qalu_pkg::OP_SUB, qalu_pkg::OP_SCALE,
                               qalu_pkg::OP_MUL, qalu_pkg::OP_CONJ, qalu_pkg::OP_NORM,
                               qalu_pkg::OP_INV};
        foreach (ops[n])
            send_item(make_item(ops[n], qalu_pkg::Q_MAX, qalu_pkg::Q_MAX, qalu_pkg::Q_MAX));
        foreach (ops[n])
            send_item(make_item(ops[n], qalu_pkg::Q_MIN, qalu_pkg::Q_MIN, qalu_pkg::Q_MIN));
        send_item(make_item(qalu_pkg::OP_INV, 32'd0, 32'd0, 32'd0));
        send_item(make_item(qalu_pkg::OP_INV, 32'h0000_0100, 32'd0, 32'd0));
        send_item(make_item(qalu_pkg::OP_NORM, 32'd0, 32'd0, 32'd0));
        send_item(make_item(qalu_pkg::OP_SCALE, 32'h0001_0000, 32'd0, 32'hFFFF_0000));
        send_item(make_item(qalu_pkg::OP_MUL, 32'h0000_8000, 32'hFFFF_8000, 32'd0));
        send_item(make_item(3'd7, qalu_pkg::Q_MAX, qalu_pkg::Q_MIN, qalu_pkg::Q_MAX));
        send_item(make_item(qalu_pkg::OP_ADD, 32'hFFFF_FFFF, 32'h0000_0001, 32'd0));
        idle_cycles(1);
    endtask

    // Random opcodes with bursty sender; the receiver stalls when stall_enable is set
    task automatic test_random(input int count, input bit pressure);
        int burst;
        int done;
        bit paused;
        done = 0;
        paused = 1'b0;
        while (done < count) begin
            burst = $urandom_range(1, 12);
            for (int n = 0; n < burst && done < count; n++) begin
                send_item(rand_item(3'($urandom_range(0, 7))));
                done++;
            end
            if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
            if (pressure && !paused && done >= count / 2) begin
                paused = 1'b1;
                idle_cycles(1);
                wait (pending_results.size() == 0);
                @(posedge aclk);
            end
        end
        idle_cycles(1);
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        stall_enable = 1'b0;
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(150, 1'b0);
        stall_enable = 1'b1;
        test_random(350, 1'b1);
        wait (pending_results.size() == 0);
        repeat (60) @(posedge aclk);
        $display("Sent %0d items over all opcodes including saturation and zero inverse,",
            items_sent);
        $display("checked %0d results with random sender gaps and receiver stalls.",
            results_seen);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/qalu_pkg.sv
rtl/qalu_front.sv
rtl/qalu_fifo.sv
rtl/qalu_exec.sv
rtl/quaternion_alu.sv
rtl/qalu_checker.sv
test/quaternion_alu_test.sv
